[rtl/core/mer_pkg.sv]
// Shared widths and codes for the midpoint ellipse rasterizer.
`timescale 1ns / 1ps
`default_nettype none
package mer_pkg;
   localparam int COORD_BITS    = 12;
   localparam int CEN_BITS      = COORD_BITS + 1;
   localparam int POS_BITS      = COORD_BITS + 2;
   localparam int DECISION_BITS = 56;
   localparam int MUL_BITS      = 32;
   localparam int PROD_BITS     = 2 * MUL_BITS;
   localparam int CSR_ADDR_BITS = 1;
   localparam int CSR_DATA_BITS = 32;

   localparam logic KIND_LOAD    = 1'b0;
   localparam logic KIND_ADVANCE = 1'b1;
   localparam logic ITEM_POINT   = 1'b0;
   localparam logic ITEM_SPAN    = 1'b1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_FILL_ENABLE = '0;
endpackage
`default_nettype wire

[rtl/core/mer_if.sv]
// Valid/ready channel interfaces for load/advance items and result items.
`timescale 1ns / 1ps
`default_nettype none
interface mer_req_if;
   logic valid;
   logic ready;
   logic kind;
   logic signed [mer_pkg::COORD_BITS-1:0] corner_a_x;
   logic signed [mer_pkg::COORD_BITS-1:0] corner_a_y;
   logic signed [mer_pkg::COORD_BITS-1:0] corner_b_x;
   logic signed [mer_pkg::COORD_BITS-1:0] corner_b_y;
   modport source (output valid, kind, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
                   input ready);
   modport sink (input valid, kind, corner_a_x, corner_a_y, corner_b_x, corner_b_y,
                 output ready);
endinterface

interface mer_rsp_if;
   logic valid;
   logic ready;
   logic item_type;
   logic signed [mer_pkg::POS_BITS-1:0] pos_x;
   logic signed [mer_pkg::POS_BITS-1:0] pos_y;
   logic signed [mer_pkg::POS_BITS-1:0] span_end_x;
   logic last_of_step;
   logic walk_done;
   modport source (output valid, item_type, pos_x, pos_y, span_end_x, last_of_step,
                   walk_done, input ready);
   modport sink (input valid, item_type, pos_x, pos_y, span_end_x, last_of_step,
                 walk_done, output ready);
endinterface
`default_nettype wire

[rtl/core/mer_mul.sv]
// Shared unsigned multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none
module mer_mul (
   input  wire logic                           clock,
   input  wire logic [mer_pkg::MUL_BITS-1:0]   op_a,
   input  wire logic [mer_pkg::MUL_BITS-1:0]   op_b,
   output logic      [mer_pkg::PROD_BITS-1:0]  prod
);
   logic [mer_pkg::PROD_BITS-1:0] prod_ff;
   logic [mer_pkg::PROD_BITS-1:0] prod_in;

   assign prod_in = mer_pkg::PROD_BITS'(op_a) * mer_pkg::PROD_BITS'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;
endmodule
`default_nettype wire

[rtl/core/midpoint_ellipse_rasterizer_core.sv]
// Top level: sequencer of the two-region midpoint ellipse walk around a shared multiplier.
// A load item (kind 0) takes two bounding-box corners and restarts the walk; it gives no
// result. An advance item (kind 1) runs one iteration and gives two fill spans or four
// outline points on the rsp channel, the last one flagged last_of_step; walk_done marks
// the final result of the ellipse. Advances while no walk is active give nothing.
// The block takes one item at a time: req.ready is high only while the sequencer idles.
// After the accepting cycle a load forms three products and the start terms and then
// settles; entering region two at once adds five more products and one more settle.
// An advance runs two update steps and a settle, five products and a settle when it enters
// region two, the start terms and a settle when it ends the fill pass and restarts, and five
// more products and a settle when the restarted pass enters region two at once; then it
// emits its results. A stalled rsp.ready holds the output register and the emitting
// sequencer waits for it.
// The last result sits in the output register while the next item is already taken.
// fill_enable is written through the csr port and sampled at each load.
// Reset is synchronous: the walk goes idle, fill_enable clears, no result is pending.
`timescale 1ns / 1ps
`default_nettype none
module midpoint_ellipse_rasterizer_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   mer_req_if.sink                                   req,
   mer_rsp_if.source                                 rsp,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [mer_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  wire logic [mer_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic      [mer_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                      csr_pready
);
   localparam int DW = mer_pkg::DECISION_BITS;
   localparam int NB = mer_pkg::CEN_BITS;
   localparam int PB = mer_pkg::POS_BITS;
   localparam int MB = mer_pkg::MUL_BITS;
   localparam int QB = mer_pkg::PROD_BITS;
   localparam int SQ = 2 * NB;          // square of a radius
   localparam int CU = 3 * NB;          // radius cubed term
   localparam int AB = PB;              // offset operand of region two entry
   localparam int A2 = 2 * AB;

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_LD1    = 5'd1;
   localparam logic [4:0] S_LD2    = 5'd2;
   localparam logic [4:0] S_LD3    = 5'd3;
   localparam logic [4:0] S_LD4    = 5'd4;
   localparam logic [4:0] S_START  = 5'd5;
   localparam logic [4:0] S_SETTLE = 5'd6;
   localparam logic [4:0] S_R1     = 5'd7;
   localparam logic [4:0] S_R2     = 5'd8;
   localparam logic [4:0] S_R3     = 5'd9;
   localparam logic [4:0] S_R4     = 5'd10;
   localparam logic [4:0] S_R5     = 5'd11;
   localparam logic [4:0] S_R6     = 5'd12;
   localparam logic [4:0] S_IT1    = 5'd13;
   localparam logic [4:0] S_IT2    = 5'd14;
   localparam logic [4:0] S_EMIT   = 5'd15;

   logic [4:0] state_ff, state_in;
   logic fill_en_ff, fill_en_in;
   logic signed [NB-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [NB-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [SQ-1:0] rx2_ff, rx2_in, ry2_ff, ry2_in;
   logic [CU-1:0] rx2ry_ff, rx2ry_in;
   logic [NB-1:0] x_ff, x_in;
   logic signed [PB-1:0] y_ff, y_in;
   logic [DW-1:0] sx_ff, sx_in, sy_ff, sy_in, dec_ff, dec_in;
   logic r2_ff, r2_in, fillpass_ff, fillpass_in, active_ff, active_in;
   logic mx_ff, mx_in, my_ff, my_in, adv_ff, adv_in, done_ff, done_in;
   logic [NB-1:0] snap_x_ff, snap_x_in;
   logic signed [PB-1:0] snap_y_ff, snap_y_in;
   logic snap_fill_ff, snap_fill_in;
   logic [A2-1:0] a2_ff, a2_in, b2_ff, b2_in;
   logic [QB-1:0] t_ff, t_in;
   logic [1:0] k_ff, k_in;
   logic ov_ff, ov_in, otype_ff, otype_in, olast_ff, olast_in, odone_ff, odone_in;
   logic signed [PB-1:0] opx_ff, opx_in, opy_ff, opy_in, oex_ff, oex_in;

   logic [MB-1:0] mul_a, mul_b;
   logic [QB-1:0] prod;
   logic req_fire, csr_write;
   logic signed [NB-1:0] dx, dy;
   logic [AB-1:0] a_op;
   logic signed [PB:0] b_op;
   logic [AB-1:0] b_mag;
   logic signed [PB:0] cxe, cye, xe, ye;
   logic [1:0] k_last;

   mer_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   assign req.ready  = (state_ff == S_IDLE);
   assign req_fire   = req.valid && req.ready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = mer_pkg::CSR_DATA_BITS'(fill_en_ff);

   assign dx = NB'(req.corner_a_x) - NB'(req.corner_b_x);
   assign dy = NB'(req.corner_a_y) - NB'(req.corner_b_y);

   assign a_op  = AB'(x_ff) + AB'(1);
   assign b_op  = (PB + 1)'(y_ff) - (PB + 1)'(2);
   assign b_mag = b_op[PB] ? AB'(-b_op) : AB'(b_op);

   assign cxe = (PB + 1)'(cx_ff);
   assign cye = (PB + 1)'(cy_ff);
   assign xe  = (PB + 1)'({1'b0, snap_x_ff});
   assign ye  = (PB + 1)'(snap_y_ff);
   assign k_last = snap_fill_ff ? 2'd1 : 2'd3;

   always_comb begin
      state_in = state_ff;
      fill_en_in = fill_en_ff;
      cx_in = cx_ff; cy_in = cy_ff; rx_in = rx_ff; ry_in = ry_ff;
      rx2_in = rx2_ff; ry2_in = ry2_ff; rx2ry_in = rx2ry_ff;
      x_in = x_ff; y_in = y_ff; sx_in = sx_ff; sy_in = sy_ff; dec_in = dec_ff;
      r2_in = r2_ff; fillpass_in = fillpass_ff; active_in = active_ff;
      mx_in = mx_ff; my_in = my_ff; adv_in = adv_ff; done_in = done_ff;
      snap_x_in = snap_x_ff; snap_y_in = snap_y_ff; snap_fill_in = snap_fill_ff;
      a2_in = a2_ff; b2_in = b2_ff; t_in = t_ff; k_in = k_ff;
      ov_in = ov_ff && !rsp.ready;
      otype_in = otype_ff; olast_in = olast_ff; odone_in = odone_ff;
      opx_in = opx_ff; opy_in = opy_ff; oex_in = oex_ff;
      mul_a = '0;
      mul_b = '0;

      if (csr_write && csr_paddr == mer_pkg::REG_FILL_ENABLE) begin
         fill_en_in = csr_pwdata[0];
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req.kind == mer_pkg::KIND_LOAD) begin
                  cx_in = NB'(req.corner_a_x) + NB'(req.corner_b_x);
                  cy_in = NB'(req.corner_a_y) + NB'(req.corner_b_y);
                  rx_in = dx[NB-1] ? NB'(-dx) : NB'(dx);
                  ry_in = dy[NB-1] ? NB'(-dy) : NB'(dy);
                  fillpass_in = fill_en_ff;
                  active_in = 1'b1;
                  adv_in = 1'b0;
                  state_in = S_LD1;
               end else if (active_ff) begin
                  snap_x_in = x_ff;
                  snap_y_in = y_ff;
                  snap_fill_in = fillpass_ff;
                  adv_in = 1'b1;
                  done_in = 1'b0;
                  state_in = S_IT1;
               end
            end
         end
         S_LD1: begin
            mul_a = MB'(rx_ff);
            mul_b = MB'(rx_ff);
            state_in = S_LD2;
         end
         S_LD2: begin
            rx2_in = prod[SQ-1:0];
            mul_a = MB'(ry_ff);
            mul_b = MB'(ry_ff);
            state_in = S_LD3;
         end
         S_LD3: begin
            ry2_in = prod[SQ-1:0];
            mul_a = MB'(rx2_ff);
            mul_b = MB'(ry_ff);
            state_in = S_LD4;
         end
         S_LD4: begin
            rx2ry_in = prod[CU-1:0];
            state_in = S_START;
         end
         S_START: begin
            x_in = '0;
            y_in = PB'(ry_ff);
            sx_in = '0;
            sy_in = DW'(rx2ry_ff) << 4;
            dec_in = (DW'(ry2_ff) << 4) - (DW'(rx2ry_ff) << 3) + (DW'(rx2_ff) << 2);
            r2_in = 1'b0;
            state_in = S_SETTLE;
         end
         S_SETTLE: begin
            if (!r2_ff && !($signed(sx_ff) < $signed(sy_ff))) begin
               state_in = S_R1;
            end else if (r2_ff && y_ff[PB-1]) begin
               if (fillpass_ff) begin
                  fillpass_in = 1'b0;
                  state_in = S_START;
               end else begin
                  active_in = 1'b0;
                  done_in = 1'b1;
                  state_in = adv_ff ? S_EMIT : S_IDLE;
               end
            end else begin
               state_in = adv_ff ? S_EMIT : S_IDLE;
            end
         end
         S_R1: begin
            mul_a = MB'(a_op);
            mul_b = MB'(a_op);
            state_in = S_R2;
         end
         S_R2: begin
            a2_in = prod[A2-1:0];
            mul_a = MB'(b_mag);
            mul_b = MB'(b_mag);
            state_in = S_R3;
         end
         S_R3: begin
            b2_in = prod[A2-1:0];
            mul_a = MB'(ry2_ff);
            mul_b = MB'(a2_ff);
            state_in = S_R4;
         end
         S_R4: begin
            t_in = prod;
            mul_a = MB'(rx2_ff);
            mul_b = MB'(b2_ff);
            state_in = S_R5;
         end
         S_R5: begin
            t_in = t_ff + prod;
            mul_a = MB'(rx2_ff);
            mul_b = MB'(ry2_ff);
            state_in = S_R6;
         end
         S_R6: begin
            dec_in = DW'((t_ff - prod) << 2);
            r2_in = 1'b1;
            state_in = S_SETTLE;
         end
         S_IT1: begin
            // Region one always steps x; region two always steps y.
            mx_in = r2_ff ? !($signed(dec_ff) > 0) : 1'b1;
            my_in = r2_ff ? 1'b1 : !dec_ff[DW-1];
            if (mx_in) begin
               sx_in = sx_ff + (DW'(ry2_ff) << 5);
               x_in = x_ff + NB'(2);
            end
            if (my_in) begin
               sy_in = sy_ff - (DW'(rx2_ff) << 5);
               y_in = y_ff - PB'(2);
            end
            state_in = S_IT2;
         end
         S_IT2: begin
            if (!r2_ff) begin
               dec_in = my_ff ? dec_ff + sx_ff - sy_ff + (DW'(ry2_ff) << 4)
                              : dec_ff + sx_ff + (DW'(ry2_ff) << 4);
            end else begin
               dec_in = mx_ff ? dec_ff + sx_ff - sy_ff + (DW'(rx2_ff) << 4)
                              : dec_ff + (DW'(rx2_ff) << 4) - sy_ff;
            end
            state_in = S_SETTLE;
         end
         S_EMIT: begin
            if (!ov_ff || rsp.ready) begin
               ov_in = 1'b1;
               olast_in = (k_ff == k_last);
               odone_in = (k_ff == k_last) && done_ff;
               if (snap_fill_ff) begin
                  otype_in = mer_pkg::ITEM_SPAN;
                  opx_in = PB'(cxe - xe);
                  oex_in = PB'(cxe + xe);
                  opy_in = (k_ff == 2'd0) ? PB'(cye + ye) : PB'(cye - ye);
               end else begin
                  otype_in = mer_pkg::ITEM_POINT;
                  opx_in = k_ff[0] ? PB'(cxe - xe) : PB'(cxe + xe);
                  opy_in = k_ff[1] ? PB'(cye - ye) : PB'(cye + ye);
                  oex_in = '0;
               end
               if (k_ff == k_last) begin
                  k_in = 2'd0;
                  state_in = S_IDLE;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_en_ff <= 1'b0;
         cx_ff <= '0; cy_ff <= '0; rx_ff <= '0; ry_ff <= '0;
         x_ff <= '0; y_ff <= '0;
         sx_ff <= '0; sy_ff <= '0; dec_ff <= '0;
         r2_ff <= 1'b0; fillpass_ff <= 1'b0; active_ff <= 1'b0;
         adv_ff <= 1'b0; done_ff <= 1'b0;
         k_ff <= 2'd0;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_en_ff <= fill_en_in;
         cx_ff <= cx_in; cy_ff <= cy_in; rx_ff <= rx_in; ry_ff <= ry_in;
         x_ff <= x_in; y_ff <= y_in;
         sx_ff <= sx_in; sy_ff <= sy_in; dec_ff <= dec_in;
         r2_ff <= r2_in; fillpass_ff <= fillpass_in; active_ff <= active_in;
         adv_ff <= adv_in; done_ff <= done_in;
         k_ff <= k_in;
         ov_ff <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      rx2_ff <= rx2_in; ry2_ff <= ry2_in; rx2ry_ff <= rx2ry_in;
      mx_ff <= mx_in; my_ff <= my_in;
      snap_x_ff <= snap_x_in; snap_y_ff <= snap_y_in; snap_fill_ff <= snap_fill_in;
      a2_ff <= a2_in; b2_ff <= b2_in; t_ff <= t_in;
      otype_ff <= otype_in; olast_ff <= olast_in; odone_ff <= odone_in;
      opx_ff <= opx_in; opy_ff <= opy_in; oex_ff <= oex_in;
   end

   assign rsp.valid        = ov_ff;
   assign rsp.item_type    = otype_ff;
   assign rsp.pos_x        = opx_ff;
   assign rsp.pos_y        = opy_ff;
   assign rsp.span_end_x   = oex_ff;
   assign rsp.last_of_step = olast_ff;
   assign rsp.walk_done    = odone_ff;

`ifndef SYNTH
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.walk_done |-> rsp.last_of_step)
      else $error("walk_done without last_of_step");

   a_hold_stable: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.pos_x) && $stable(rsp.pos_y)
         && $stable(rsp.last_of_step))
      else $error("result item changed while stalled");

   a_point_no_end: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.item_type == mer_pkg::ITEM_POINT |-> rsp.span_end_x == '0)
      else $error("outline point carries a span end");
`endif
endmodule
`default_nettype wire

[tb/midpoint_ellipse_rasterizer_checker.sv]
// Predicts and checks the result items of the midpoint ellipse rasterizer.
`timescale 1ns / 1ps
module midpoint_ellipse_rasterizer_checker (
   input  logic        clock,
   input  logic        reset,
   mer_req_if          req,
   mer_rsp_if          rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [mer_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [mer_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   input  logic        csr_pready,
   output int          error_count,
   output int          pending
);
   typedef struct {
      logic                         item_type;
      logic [mer_pkg::POS_BITS-1:0] pos_x;
      logic [mer_pkg::POS_BITS-1:0] pos_y;
      logic [mer_pkg::POS_BITS-1:0] span_end_x;
      logic                         last_of_step;
      logic                         walk_done;
   } raster_item_type;

   raster_item_type expected_items[$];

   // Shadow copy of the block's configuration and walk state.
   logic                                fill_on;
   int                                  ctr_x, ctr_y;
   logic [63:0]                         rad_x, rad_y;
   logic [mer_pkg::CEN_BITS-1:0]        off_x;
   logic signed [mer_pkg::POS_BITS-1:0] off_y;
   logic [mer_pkg::DECISION_BITS-1:0]   slope_x, slope_y, dec_term;
   logic                                region_two, filling, walking;

   assign pending = expected_items.size();

   function automatic void begin_pass();
      off_x = '0;
      off_y = rad_y[mer_pkg::POS_BITS-1:0];
      slope_x = '0;
      slope_y = mer_pkg::DECISION_BITS'(16 * rad_x * rad_x * rad_y);
      dec_term = mer_pkg::DECISION_BITS'(16 * rad_y * rad_y - 8 * rad_x * rad_x * rad_y
                                         + 4 * rad_x * rad_x);
      region_two = 1'b0;
   endfunction

   function automatic void switch_region();
      logic [63:0] rx2, ry2, a, b;
      rx2 = rad_x * rad_x;
      ry2 = rad_y * rad_y;
      a = 64'(off_x) + 64'd1;
      b = 64'(longint'(off_y) - 2);
      dec_term = mer_pkg::DECISION_BITS'(4 * (ry2 * a * a + rx2 * b * b - rx2 * ry2));
      region_two = 1'b1;
   endfunction

   // Returns 1 when the whole ellipse has been walked.
   function automatic logic advance_phase();
      if (!region_two && !($signed(slope_x) < $signed(slope_y)))
         switch_region();
      if (region_two && off_y < 0) begin
         if (filling) begin
            filling = 1'b0;
            begin_pass();
            if (!($signed(slope_x) < $signed(slope_y)))
               switch_region();
         end else begin
            walking = 1'b0;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void walk_iteration();
      logic [63:0] rx2, ry2;
      logic mv_x, mv_y;
      rx2 = rad_x * rad_x;
      ry2 = rad_y * rad_y;
      if (!region_two) begin
         mv_x = 1'b1;
         mv_y = $signed(dec_term) >= 0;
      end else begin
         mv_y = 1'b1;
         mv_x = !($signed(dec_term) > 0);
      end
      if (mv_x) slope_x = mer_pkg::DECISION_BITS'(slope_x + 32 * ry2);
      if (mv_y) slope_y = mer_pkg::DECISION_BITS'(slope_y - 32 * rx2);
      if (!region_two) begin
         if (mv_y) dec_term = mer_pkg::DECISION_BITS'(dec_term + slope_x - slope_y + 16 * ry2);
         else      dec_term = mer_pkg::DECISION_BITS'(dec_term + slope_x + 16 * ry2);
      end else begin
         if (mv_x) dec_term = mer_pkg::DECISION_BITS'(dec_term + slope_x - slope_y + 16 * rx2);
         else      dec_term = mer_pkg::DECISION_BITS'(dec_term + 16 * rx2 - slope_y);
      end
      if (mv_x) off_x = off_x + mer_pkg::CEN_BITS'(2);
      if (mv_y) off_y = off_y - mer_pkg::POS_BITS'(2);
   endfunction

   function automatic raster_item_type make_item(logic kind_span, int px, int py, int ex);
      raster_item_type it;
      it.item_type = kind_span;
      it.pos_x = mer_pkg::POS_BITS'(px);
      it.pos_y = mer_pkg::POS_BITS'(py);
      it.span_end_x = mer_pkg::POS_BITS'(ex);
      it.last_of_step = 1'b0;
      it.walk_done = 1'b0;
      return it;
   endfunction

   task automatic predict_raster(logic kind, int ax, int ay, int bx, int by);
      raster_item_type batch[$];
      int x, y;
      logic fin;
      if (kind == mer_pkg::KIND_LOAD) begin
         ctr_x = ax + bx;
         ctr_y = ay + by;
         rad_x = 64'(ax > bx ? ax - bx : bx - ax);
         rad_y = 64'(ay > by ? ay - by : by - ay);
         filling = fill_on;
         walking = 1'b1;
         begin_pass();
         fin = advance_phase();
         return;
      end
      if (!walking) return;
      x = int'(off_x);
      y = int'(off_y);
      if (filling) begin
         batch.push_back(make_item(mer_pkg::ITEM_SPAN, ctr_x - x, ctr_y + y, ctr_x + x));
         batch.push_back(make_item(mer_pkg::ITEM_SPAN, ctr_x - x, ctr_y - y, ctr_x + x));
      end else begin
         batch.push_back(make_item(mer_pkg::ITEM_POINT, ctr_x + x, ctr_y + y, 0));
         batch.push_back(make_item(mer_pkg::ITEM_POINT, ctr_x - x, ctr_y + y, 0));
         batch.push_back(make_item(mer_pkg::ITEM_POINT, ctr_x + x, ctr_y - y, 0));
         batch.push_back(make_item(mer_pkg::ITEM_POINT, ctr_x - x, ctr_y - y, 0));
      end
      walk_iteration();
      fin = advance_phase();
      batch[batch.size()-1].last_of_step = 1'b1;
      batch[batch.size()-1].walk_done = fin;
      foreach (batch[i]) expected_items.push_back(batch[i]);
   endtask

   initial error_count = 0;

   always @(posedge clock) begin : watch
      raster_item_type want;
      if (reset) begin
         fill_on = 1'b0;
         ctr_x = 0; ctr_y = 0; rad_x = '0; rad_y = '0;
         off_x = '0; off_y = '0; slope_x = '0; slope_y = '0; dec_term = '0;
         region_two = 1'b0; filling = 1'b0; walking = 1'b0;
         expected_items.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_items.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: unexpected result item x=%0d y=%0d", $realtime,
                           rsp.pos_x, rsp.pos_y);
            end else begin
               want = expected_items.pop_front();
               if (rsp.item_type !== want.item_type || rsp.pos_x !== want.pos_x ||
                   rsp.pos_y !== want.pos_y || rsp.span_end_x !== want.span_end_x ||
                   rsp.last_of_step !== want.last_of_step ||
                   rsp.walk_done !== want.walk_done) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("%0t: result item mismatch exp t=%0b x=%0d y=%0d e=%0d l=%0b d=%0b",
                              $realtime, want.item_type, $signed(want.pos_x),
                              $signed(want.pos_y), $signed(want.span_end_x),
                              want.last_of_step, want.walk_done,
                              " got t=%0b x=%0d y=%0d e=%0d l=%0b d=%0b",
                              rsp.item_type, rsp.pos_x, rsp.pos_y, rsp.span_end_x,
                              rsp.last_of_step, rsp.walk_done);
               end
            end
         end
         if (req.valid && req.ready)
            predict_raster(req.kind, int'(req.corner_a_x), int'(req.corner_a_y),
                           int'(req.corner_b_x), int'(req.corner_b_y));
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == mer_pkg::REG_FILL_ENABLE)
            fill_on = csr_pwdata[0];
      end
   end
endmodule

[tb/midpoint_ellipse_rasterizer_core_test.sv]
// Stimulus, handshake pacing and verdict for the midpoint ellipse rasterizer.
`timescale 1ns / 1ps
module midpoint_ellipse_rasterizer_core_test;
   localparam int STALL_LIMIT = 3000;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [mer_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [mer_pkg::CSR_DATA_BITS-1:0] csr_pwdata, csr_prdata;
   int   error_count, pending;
   logic hold_request;
   int   quiet_cycles;

   mer_req_if req_bus();
   mer_rsp_if rsp_bus();

   midpoint_ellipse_rasterizer_core u_dut (
      .clock(clock), .reset(reset), .req(req_bus), .rsp(rsp_bus),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   midpoint_ellipse_rasterizer_checker u_checker (
      .clock(clock), .reset(reset), .req(req_bus), .rsp(rsp_bus),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .error_count(error_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(15, 50);
   endfunction

   // Result side: random back-pressure, plus one long hold-off on request.
   initial begin
      int n;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (199) @(negedge clock);
            hold_request = 1'b0;
         end else if ($urandom_range(0, 99) < 60) begin
            rsp_bus.ready <= 1'b1;
            n = $urandom_range(1, 12);
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b0;
            n = pick_gap();
            repeat (n) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_item(logic kind, logic [mer_pkg::COORD_BITS-1:0] ax,
                            logic [mer_pkg::COORD_BITS-1:0] ay,
                            logic [mer_pkg::COORD_BITS-1:0] bx,
                            logic [mer_pkg::COORD_BITS-1:0] by);
      int gap;
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.kind <= kind;
      req_bus.corner_a_x <= ax;
      req_bus.corner_a_y <= ay;
      req_bus.corner_b_x <= bx;
      req_bus.corner_b_y <= by;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic advance_walk(int count);
      repeat (count)
         send_item(mer_pkg::KIND_ADVANCE, mer_pkg::COORD_BITS'($urandom),
                   mer_pkg::COORD_BITS'($urandom), mer_pkg::COORD_BITS'($urandom),
                   mer_pkg::COORD_BITS'($urandom));
   endtask

   // A small box somewhere on the plane, so a whole walk stays short.
   task automatic load_small_box();
      int ax, ay;
      ax = $urandom_range(0, 4000) - 2000;
      ay = $urandom_range(0, 4000) - 2000;
      send_item(mer_pkg::KIND_LOAD, mer_pkg::COORD_BITS'(ax), mer_pkg::COORD_BITS'(ay),
                mer_pkg::COORD_BITS'(ax + $urandom_range(0, 16) - 8),
                mer_pkg::COORD_BITS'(ay + $urandom_range(0, 16) - 8));
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      // A load leaves no result behind, so give it time to finish.
      repeat (30) @(posedge clock);
   endtask

   task automatic write_fill(logic value);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= mer_pkg::REG_FILL_ENABLE;
      csr_pwdata <= {{(mer_pkg::CSR_DATA_BITS-1){1'b0}}, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      int sent;
      hold_request = 1'b0;
      reset = 1'b1;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      req_bus.valid = 1'b0; req_bus.kind = mer_pkg::KIND_LOAD;
      req_bus.corner_a_x = '0; req_bus.corner_a_y = '0;
      req_bus.corner_b_x = '0; req_bus.corner_b_y = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: advance while idle, degenerate boxes, extremes, a restart mid-walk.
      advance_walk(1);
      write_fill(1'b1);
      send_item(mer_pkg::KIND_LOAD, 12'sd5, -12'sd3, 12'sd5, -12'sd3);
      advance_walk(3);
      send_item(mer_pkg::KIND_LOAD, 12'sd0, -12'sd2, 12'sd0, 12'sd2);
      advance_walk(5);
      send_item(mer_pkg::KIND_LOAD, -12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047);
      advance_walk(3);
      send_item(mer_pkg::KIND_LOAD, 12'sd2047, 12'sd2047, -12'sd2048, -12'sd2048);
      advance_walk(2);
      send_item(mer_pkg::KIND_LOAD, 12'sd1, 12'sd0, 12'sd4, 12'sd2);
      advance_walk(6);
      drain_results();
      write_fill(1'b0);
      send_item(mer_pkg::KIND_LOAD, -12'sd4, 12'sd7, 12'sd3, 12'sd7);
      advance_walk(6);
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         write_fill(phase[0] ? 1'b0 : 1'b1);
         sent = 0;
         if (phase == 1) begin
            // Let results back up until the block stalls its input.
            send_item(mer_pkg::KIND_LOAD, 12'sd0, 12'sd0, 12'sd7, 12'sd6);
            hold_request = 1'b1;
            advance_walk(16);
            sent = 17;
         end
         while (sent < 30) begin
            if ($urandom_range(0, 9) == 0) begin
               send_item(mer_pkg::KIND_LOAD, mer_pkg::COORD_BITS'($urandom),
                         mer_pkg::COORD_BITS'($urandom), mer_pkg::COORD_BITS'($urandom),
                         mer_pkg::COORD_BITS'($urandom));
               advance_walk(2);
               sent += 3;
            end else begin
               load_small_box();
               begin
                  int n;
                  n = $urandom_range(1, 24);
                  advance_walk(n);
                  sent += n + 1;
               end
            end
         end
         drain_results();
      end

      if (error_count == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

[files.f]
rtl/core/mer_pkg.sv
rtl/core/mer_if.sv
rtl/core/mer_mul.sv
rtl/core/midpoint_ellipse_rasterizer_core.sv
tb/midpoint_ellipse_rasterizer_checker.sv
tb/midpoint_ellipse_rasterizer_core_test.sv
